>>> design/lru_pkg.sv
package lru_pkg;

    localparam int CFG_W     = 4;
    localparam int FAULT_W   = 32;
    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic en;
        logic is_new;
    } t_touch_ctl;

endpackage

>>> design/lru_page_mem.sv
module lru_page_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lru_rank_file.sv
module lru_rank_file #(
    parameter int MAX_FRAMES = 8,
    parameter int FW         = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lru_pkg::t_touch_ctl       i_touch,
    input  logic [FW-1:0]             i_touch_idx,
    input  logic [FW-1:0]             i_rd_idx,
    output logic                      o_rd_valid,
    output logic [FW-1:0]             o_rd_rank
);
    import lru_pkg::*;

    logic [MAX_FRAMES-1:0] r_valid;
    logic [FW-1:0]         r_rank [MAX_FRAMES];
    logic [FW-1:0]         sel_rank;

    assign sel_rank   = r_rank[i_touch_idx];
    assign o_rd_valid = r_valid[i_rd_idx];
    assign o_rd_rank  = r_rank[i_rd_idx];

    // hit/replace: age frames younger than the touched one; fill: age all valid frames
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_touch.en) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                if (r_valid[i] && (i_touch.is_new || (r_rank[i] < sel_rank))) begin
                    r_rank[i] <= r_rank[i] + FW'(1);
                end
            end
            r_rank[i_touch_idx] <= '0;
            if (i_touch.is_new) begin
                r_valid[i_touch_idx] <= 1'b1;
            end
        end
    end

endmodule

>>> design/lru_page_replacement_core.sv
// Channel   Dir  Handshake                  Payload
// s_axis    in   i_s_axis_tvalid/o_..tready tdata: page_number
// m_axis    out  o_m_axis_tvalid/i_..tready tdata: frame_index, evicted_page, fault_total
//                                           tuser: hit, evicted_valid
// cfg       in   i_cfg_we                   i_cfg_wdata: frames_in_use
//
// For each reference, after accept the n active frames (n = active frames) are
// scanned one per cycle through the page memory read port, then the update state
// commits the rank update and the result before the next accept.
// Synchronous active-low reset clears valid bits, ranks and the fault count.
// A result waits in the output register; the commit stalls only while it is not taken.
module lru_page_replacement_core #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16,
    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    localparam int CW = $clog2(MAX_FRAMES + 1),
    localparam int IW = ((PAGE_BITS + 7) / 8) * 8,
    localparam int OW = ((FW + PAGE_BITS + lru_pkg::FAULT_W + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [lru_pkg::CFG_W-1:0] i_cfg_wdata,   // frames_in_use
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [IW-1:0]            i_s_axis_tdata, // page_number
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [OW-1:0]            o_m_axis_tdata, // frame_index, evicted_page, fault_total
    output logic [1:0]               o_m_axis_tuser  // hit, evicted_valid
);
    import lru_pkg::*;

    t_state r_state, n_state;

    logic [CFG_W-1:0]     r_cfg;
    logic [CW-1:0]        n_act;
    logic [31:0]          cfg_ext;

    logic [PAGE_BITS-1:0] r_page;
    logic [CW-1:0]        r_idx;
    logic                 r_cmp_vld;
    logic [FW-1:0]        r_cmp_idx;
    logic                 r_hit_found, r_empty_found;
    logic [FW-1:0]        r_hit_idx, r_empty_idx, r_best_idx;
    logic [FW-1:0]        r_best_rank;
    logic [PAGE_BITS-1:0] r_best_page;
    logic [FAULT_W-1:0]   r_fault, n_fault;

    logic                 r_out_valid, r_out_hit, r_out_ev;
    logic [FW-1:0]        r_out_frame;
    logic [PAGE_BITS-1:0] r_out_evpage;
    logic [FAULT_W-1:0]   r_out_fault;

    logic                 s_ready, issue, commit;
    logic                 accept;
    logic                 is_hit, is_empty, is_better;
    logic [FW-1:0]        frame_sel;
    logic                 rd_valid;
    logic [FW-1:0]        rd_rank;
    logic [PAGE_BITS-1:0] mem_rdata;
    t_touch_ctl           touch;

    assign cfg_ext = 32'(r_cfg);
    always_comb begin
        if (cfg_ext == 32'd0) begin
            n_act = CW'(1);
        end else if (cfg_ext > 32'(MAX_FRAMES)) begin
            n_act = CW'(MAX_FRAMES);
        end else begin
            n_act = CW'(cfg_ext);
        end
    end

    assign issue  = (r_idx < n_act);
    assign accept = i_s_axis_tvalid && s_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_s_axis_tvalid) n_state = ST_SCAN;
            ST_SCAN:   if (!issue) n_state = ST_UPDATE;
            ST_UPDATE: if (!r_out_valid || i_m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        commit  = 1'b0;
        unique case (r_state)
            ST_IDLE:   s_ready = 1'b1;
            ST_SCAN:   ;
            ST_UPDATE: commit = !r_out_valid || i_m_axis_tready;
            default:   ;
        endcase
    end

    // scan compare stage, aligned with the registered memory read
    assign is_hit    = r_cmp_vld && !r_hit_found && rd_valid && (mem_rdata == r_page);
    assign is_empty  = r_cmp_vld && !r_empty_found && !rd_valid;
    assign is_better = r_cmp_vld && ((r_cmp_idx == '0) || (rd_rank > r_best_rank));

    always_comb begin
        priority if (r_hit_found) begin
            frame_sel = r_hit_idx;
        end else if (r_empty_found) begin
            frame_sel = r_empty_idx;
        end else begin
            frame_sel = r_best_idx;
        end
    end

    assign touch.en     = commit;
    assign touch.is_new = !r_hit_found && r_empty_found;
    assign n_fault      = (r_fault == FAULT_MAX) ? r_fault : r_fault + FAULT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= CFG_RESET;
            r_cmp_vld   <= 1'b0;
            r_fault     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_cmp_vld <= (r_state == ST_SCAN) && issue;
            if (commit && !r_hit_found) begin
                r_fault <= n_fault;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page        <= i_s_axis_tdata[PAGE_BITS-1:0];
            r_idx         <= '0;
            r_hit_found   <= 1'b0;
            r_empty_found <= 1'b0;
        end
        if ((r_state == ST_SCAN) && issue) begin
            r_idx     <= r_idx + CW'(1);
            r_cmp_idx <= r_idx[FW-1:0];
        end
        if (is_hit) begin
            r_hit_found <= 1'b1;
            r_hit_idx   <= r_cmp_idx;
        end
        if (is_empty) begin
            r_empty_found <= 1'b1;
            r_empty_idx   <= r_cmp_idx;
        end
        if (is_better) begin
            r_best_idx  <= r_cmp_idx;
            r_best_rank <= rd_rank;
            r_best_page <= mem_rdata;
        end
        if (commit) begin
            r_out_hit    <= r_hit_found;
            r_out_frame  <= frame_sel;
            r_out_ev     <= !r_hit_found && !r_empty_found;
            r_out_evpage <= (!r_hit_found && !r_empty_found) ? r_best_page : '0;
            r_out_fault  <= r_hit_found ? r_fault : n_fault;
        end
    end

    lru_page_mem #(
        .DEPTH (MAX_FRAMES),
        .AW    (FW),
        .DW    (PAGE_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (commit && !r_hit_found),
        .i_waddr (frame_sel),
        .i_wdata (r_page),
        .i_re    ((r_state == ST_SCAN) && issue),
        .i_raddr (r_idx[FW-1:0]),
        .o_rdata (mem_rdata)
    );

    lru_rank_file #(
        .MAX_FRAMES (MAX_FRAMES),
        .FW         (FW)
    ) u_rank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_touch     (touch),
        .i_touch_idx (frame_sel),
        .i_rd_idx    (r_cmp_idx),
        .o_rd_valid  (rd_valid),
        .o_rd_rank   (rd_rank)
    );

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OW'({r_out_fault, r_out_evpage, r_out_frame});
    assign o_m_axis_tuser  = {r_out_ev, r_out_hit};

endmodule

>>> tb/lru_scoreboard.sv
module lru_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [15:0] i_s_data,   // page_number
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [55:0] i_m_data,   // frame_index, evicted_page, fault_total
    input  logic [1:0]  i_m_user,   // hit, evicted_valid
    output int          o_fail_count,
    output int          o_pending
);
    import lru_pkg::*;

    localparam int NUM_FRAMES = 8;

    typedef struct packed {
        logic        hit;
        logic [2:0]  frame;
        logic        evicted;
        logic [15:0] evicted_page;
        logic [31:0] faults;
    } t_page_outcome;

    logic               resident[NUM_FRAMES];
    logic [15:0]        tag[NUM_FRAMES];
    logic [2:0]         age[NUM_FRAMES];
    logic [FAULT_W-1:0] fault_count;
    logic [CFG_W-1:0]   frames_cfg;
    t_page_outcome      outcome_q[$];
    int                 errors = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < 40)
            $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // frame f becomes most recent; younger resident frames age by one
    task automatic promote_frame(input int f);
        logic [2:0] r;
        r = age[f];
        for (int i = 0; i < NUM_FRAMES; i++)
            if (resident[i] && age[i] < r) age[i] = age[i] + 3'd1;
        age[f] = 3'd0;
    endtask

    task automatic reference_page(input logic [15:0] pg, output t_page_outcome res);
        int  n;
        int  f;
        bit  found;
        n = int'(frames_cfg);
        if (n == 0) n = 1;
        if (n > NUM_FRAMES) n = NUM_FRAMES;
        res   = '0;
        found = 1'b0;
        f     = 0;
        for (int i = 0; i < n; i++) begin
            if (!found && resident[i] && tag[i] == pg) begin
                found = 1'b1;
                f     = i;
            end
        end
        if (found) begin
            res.hit = 1'b1;
            promote_frame(f);
        end else begin
            for (int i = 0; i < n; i++) begin
                if (!found && !resident[i]) begin
                    found = 1'b1;
                    f     = i;
                end
            end
            if (found) begin
                for (int i = 0; i < NUM_FRAMES; i++)
                    if (resident[i]) age[i] = age[i] + 3'd1;
                age[f]      = 3'd0;
                resident[f] = 1'b1;
                tag[f]      = pg;
            end else begin
                f = 0;
                for (int i = 1; i < n; i++)
                    if (age[i] > age[f]) f = i;
                res.evicted      = 1'b1;
                res.evicted_page = tag[f];
                tag[f]           = pg;
                promote_frame(f);
            end
            if (fault_count != FAULT_MAX) fault_count = fault_count + FAULT_W'(1);
        end
        res.frame  = f[2:0];
        res.faults = fault_count;
    endtask

    always @(posedge i_clk) begin
        t_page_outcome want;
        t_page_outcome got;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
                resident[i] = 1'b0;
                tag[i]      = '0;
                age[i]      = '0;
            end
            fault_count = '0;
            frames_cfg  = CFG_RESET;
            outcome_q.delete();
        end else begin
            if (i_m_valid && i_m_ready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("unexpected transaction", 64'(i_m_data), 64'(0));
                end else begin
                    want = outcome_q.pop_front();
                    got.hit          = i_m_user[0];
                    got.evicted      = i_m_user[1];
                    got.frame        = i_m_data[2:0];
                    got.evicted_page = i_m_data[18:3];
                    got.faults       = i_m_data[50:19];
                    if (got.hit !== want.hit)
                        report_mismatch("hit", 64'(got.hit), 64'(want.hit));
                    if (got.frame !== want.frame)
                        report_mismatch("frame_index", 64'(got.frame), 64'(want.frame));
                    if (got.evicted !== want.evicted)
                        report_mismatch("evicted_valid", 64'(got.evicted),
                                        64'(want.evicted));
                    if (got.evicted_page !== want.evicted_page)
                        report_mismatch("evicted_page", 64'(got.evicted_page),
                                        64'(want.evicted_page));
                    if (got.faults !== want.faults)
                        report_mismatch("fault_total", 64'(got.faults), 64'(want.faults));
                end
            end
            if (i_s_valid && i_s_ready) begin
                reference_page(i_s_data, want);
                outcome_q.push_back(want);
            end
            if (i_cfg_we) frames_cfg = i_cfg_wdata;
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= errors;
    end

endmodule

>>> tb/tb_lru_page_replacement_core.sv
module tb_lru_page_replacement_core;
    import lru_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic [15:0]        s_data    = '0;   // page_number
    logic               s_ready;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [55:0]        m_data;           // frame_index, evicted_page, fault_total
    logic [1:0]         m_user;           // hit, evicted_valid
    int                 fail_count;
    int                 pending;
    int                 idle_pct  = 0;
    int                 stall_pct = 0;
    int                 hold_seq  = 0;
    int                 hold_seen = 0;
    int                 quiet     = 0;

    lru_page_replacement_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    lru_scoreboard checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_valid    (s_valid),
        .i_s_ready    (s_ready),
        .i_s_data     (s_data),
        .i_m_valid    (m_valid),
        .i_m_ready    (m_ready),
        .i_m_data     (m_data),
        .i_m_user     (m_user),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                m_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic offer_page(input logic [15:0] pg);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= pg;
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_frames(input logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly a small pool so hits and replacements are frequent
    function automatic logic [15:0] pick_page(input int n);
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return 16'($urandom_range(n + 3, 0));
        if (sel < 80) return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    initial begin
        logic [CFG_W-1:0] phase_frames[12];
        logic [15:0]      warmup[12];
        int               n;
        phase_frames = '{4'd15, 4'd1, 4'd8, 4'd3, 4'd0, 4'd6,
                         4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd8};
        warmup = '{16'h0000, 16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001,
                   16'h0002, 16'h0003, 16'h0004, 16'h0000, 16'h0009, 16'hFFFF};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill all frames, hit, then two replacements
        set_frames(4'd8);
        foreach (warmup[i]) offer_page(warmup[i]);
        drain_results();

        // shrink: upper frames keep their pages but stop matching
        set_frames(4'd2);
        offer_page(16'h0003);
        offer_page(16'h0000);
        offer_page(16'h0003);
        drain_results();

        // zero acts as one frame
        set_frames(4'd0);
        offer_page(16'h0007);
        offer_page(16'h0003);
        offer_page(16'h0007);
        drain_results();

        // oversized count acts as full set; old pages match again
        set_frames(4'd15);
        offer_page(16'h0004);
        offer_page(16'h5555);
        offer_page(16'h8000);
        drain_results();

        for (int phase = 0; phase < 12; phase++) begin
            set_frames(phase_frames[phase]);
            n = int'(phase_frames[phase]);
            if (n == 0) n = 1;
            if (n > 8) n = 8;
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 74; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 74; end
                default: begin idle_pct = 34; stall_pct <= 34; end
            endcase
            if (phase == 2) hold_seq <= hold_seq + 1;
            for (int k = 0; k < 50; k++) offer_page(pick_page(n));
            drain_results();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
